[rtl/core/sts_pkg.sv]
// Shared types, constants and the sequencer program of the square tile size search.
package sts_pkg;

  localparam int CountW = 11;
  localparam int SideW = 32;
  localparam int MaxTiles = 1024;
  localparam int DimBitsDefault = 16;
  localparam int FracBitsDefault = 16;
  localparam int StepW = 3;

  localparam logic [StepW-1:0] StepSx    = 3'd0;
  localparam logic [StepW-1:0] StepSide  = 3'd1;
  localparam logic [StepW-1:0] StepCheck = 3'd2;
  localparam logic [StepW-1:0] StepBest  = 3'd3;
  localparam logic [StepW-1:0] StepDec   = 3'd4;
  localparam logic [StepW-1:0] StepRows  = 3'd5;
  localparam logic [StepW-1:0] StepEmit  = 3'd6;

  typedef enum logic [1:0] {
    SEL_W_COLS,
    SEL_H_ROWS,
    SEL_N_COLS
  } sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SX,
    WR_SIDE,
    WR_ROWS
  } wr_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_LESS,
    JMP_COL_ONE
  } jmp_e;

  typedef struct packed {
    logic             div_go;
    sel_e             div_sel;
    wr_e              wr;
    logic             best_en;
    logic             dec_cols;
    logic             emit;
    jmp_e             jmp;
    logic [StepW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic div_start;
    sel_e div_sel;
    wr_e  wr;
    logic best_en;
    logic dec_cols;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic less;
    logic col_one;
  } stat_t;

  function automatic ucode_t ucode(input logic [StepW-1:0] step);
    ucode_t cw;
    cw = '{div_go: 1'b0, div_sel: SEL_W_COLS, wr: WR_NONE, best_en: 1'b0,
           dec_cols: 1'b0, emit: 1'b0, jmp: JMP_NONE, target: StepSx};
    unique case (step)
      StepSx: begin
        cw.div_go = 1'b1;
        cw.div_sel = SEL_W_COLS;
        cw.wr = WR_SX;
      end
      StepSide: begin
        cw.div_go = 1'b1;
        cw.div_sel = SEL_H_ROWS;
        cw.wr = WR_SIDE;
      end
      StepCheck: begin
        cw.jmp = JMP_LESS;
        cw.target = StepEmit;
      end
      StepBest: begin
        cw.best_en = 1'b1;
        cw.jmp = JMP_COL_ONE;
        cw.target = StepEmit;
      end
      StepDec: begin
        cw.dec_cols = 1'b1;
      end
      StepRows: begin
        cw.div_go = 1'b1;
        cw.div_sel = SEL_N_COLS;
        cw.wr = WR_ROWS;
        cw.jmp = JMP_ALWAYS;
        cw.target = StepSx;
      end
      StepEmit: begin
        cw.emit = 1'b1;
      end
      default: begin
        cw.emit = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

[rtl/core/sts_divider.sv]
// Shared restoring divider that produces one quotient bit per cycle.
module sts_divider #(
  parameter int QW = 32,
  parameter int DW = sts_pkg::CountW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o,
  output logic          done_o
);

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[QW-1]};
  assign diff = trial - {1'b0, dvs_q};
  assign ge = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[QW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign remainder_o = rem_q;
  assign done_o = done_q;

endmodule

[rtl/core/sts_sequencer.sv]
// Step counter that walks the control program and issues control words.
module sts_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          div_done_i,
  input  sts_pkg::stat_t stat_i,
  output sts_pkg::ctrl_t ctrl_o,
  output logic          busy_o
);

  logic                      busy_q, busy_d;
  logic                      launched_q, launched_d;
  logic [sts_pkg::StepW-1:0] step_q, step_d;
  sts_pkg::ucode_t           cw;
  logic                      taken;

  assign cw = sts_pkg::ucode(step_q);

  always_comb begin
    unique case (cw.jmp)
      sts_pkg::JMP_NONE:    taken = 1'b0;
      sts_pkg::JMP_ALWAYS:  taken = 1'b1;
      sts_pkg::JMP_LESS:    taken = stat_i.less;
      sts_pkg::JMP_COL_ONE: taken = stat_i.col_one;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    launched_d = launched_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        launched_d = 1'b0;
        step_d = sts_pkg::StepSx;
      end
    end else if (cw.div_go && !launched_q) begin
      launched_d = 1'b1;
    end else if (cw.div_go && !div_done_i) begin
      launched_d = 1'b1;
    end else if (cw.emit) begin
      busy_d = 1'b0;
    end else begin
      launched_d = 1'b0;
      step_d = taken ? cw.target : step_q + sts_pkg::StepW'(1);
    end
  end

  always_comb begin
    ctrl_o = '{load: 1'b0, div_start: 1'b0, div_sel: cw.div_sel, wr: sts_pkg::WR_NONE,
               best_en: 1'b0, dec_cols: 1'b0, emit: 1'b0};
    if (!busy_q) begin
      ctrl_o.load = start_i;
    end else if (cw.div_go) begin
      ctrl_o.div_start = !launched_q;
      if (launched_q && div_done_i) begin
        ctrl_o.wr = cw.wr;
      end
    end else begin
      ctrl_o.best_en = cw.best_en;
      ctrl_o.dec_cols = cw.dec_cols;
      ctrl_o.emit = cw.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      launched_q <= 1'b0;
      step_q <= sts_pkg::StepSx;
    end else begin
      busy_q <= busy_d;
      launched_q <= launched_d;
      step_q <= step_d;
    end
  end

  assign busy_o = busy_q;

endmodule

[rtl/core/sts_datapath.sv]
// Search registers, divider operand selection and the result register.
module sts_datapath #(
  parameter int DIM_BITS = sts_pkg::DimBitsDefault,
  parameter int FRAC_BITS = sts_pkg::FracBitsDefault,
  parameter int QW = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sts_pkg::ctrl_t             ctrl_i,
  input  logic [DIM_BITS-1:0]        rect_width_i,
  input  logic [DIM_BITS-1:0]        rect_height_i,
  input  logic [sts_pkg::CountW-1:0] tile_count_i,
  input  logic [QW-1:0]              quotient_i,
  input  logic [sts_pkg::CountW-1:0] remainder_i,
  output logic [QW-1:0]              dividend_o,
  output logic [sts_pkg::CountW-1:0] divisor_o,
  output sts_pkg::stat_t             stat_o,
  output logic                       done_o,
  output logic [sts_pkg::SideW-1:0]  tile_side_o,
  output logic [sts_pkg::CountW-1:0] grid_columns_o,
  output logic [sts_pkg::CountW-1:0] grid_rows_o
);

  localparam int CW = sts_pkg::CountW;

  logic [DIM_BITS-1:0]       w_q, h_q;
  logic [CW-1:0]             n_q, cols_q, rows_q, best_cols_q, best_rows_q;
  logic [QW-1:0]             sx_q, side_q, best_q;
  logic [CW-1:0]             n_in;
  logic [QW-1:0]             side_min;
  logic [CW-1:0]             rows_ceil;
  logic                      done_q;
  logic [sts_pkg::SideW-1:0] res_side_q;
  logic [CW-1:0]             res_cols_q, res_rows_q;

  always_comb begin
    n_in = tile_count_i;
    if (tile_count_i == '0) begin
      n_in = CW'(1);
    end
    if (32'(tile_count_i) > 32'(sts_pkg::MaxTiles)) begin
      n_in = CW'(sts_pkg::MaxTiles);
    end
  end

  always_comb begin
    case (ctrl_i.div_sel)
      sts_pkg::SEL_W_COLS: begin
        dividend_o = QW'(w_q) << FRAC_BITS;
        divisor_o = cols_q;
      end
      sts_pkg::SEL_H_ROWS: begin
        dividend_o = QW'(h_q) << FRAC_BITS;
        divisor_o = rows_q;
      end
      default: begin
        dividend_o = QW'(n_q);
        divisor_o = cols_q;
      end
    endcase
  end

  assign side_min = (sx_q < quotient_i) ? sx_q : quotient_i;
  assign rows_ceil = quotient_i[CW-1:0] + CW'(remainder_i != '0);

  assign stat_o.less = side_q < best_q;
  assign stat_o.col_one = cols_q == CW'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      w_q <= rect_width_i;
      h_q <= rect_height_i;
      n_q <= n_in;
      cols_q <= n_in;
      rows_q <= CW'(1);
      best_q <= '0;
      best_cols_q <= n_in;
      best_rows_q <= CW'(1);
    end else begin
      if (ctrl_i.dec_cols) begin
        cols_q <= cols_q - CW'(1);
      end
      if (ctrl_i.wr == sts_pkg::WR_ROWS) begin
        rows_q <= rows_ceil;
      end
      if (ctrl_i.best_en) begin
        best_q <= side_q;
        best_cols_q <= cols_q;
        best_rows_q <= rows_q;
      end
    end
    if (ctrl_i.wr == sts_pkg::WR_SX) begin
      sx_q <= quotient_i;
    end
    if (ctrl_i.wr == sts_pkg::WR_SIDE) begin
      side_q <= side_min;
    end
    if (ctrl_i.emit) begin
      res_side_q <= (64'(best_q) > 64'hFFFF_FFFF) ? '1 : sts_pkg::SideW'(best_q);
      res_cols_q <= best_cols_q;
      res_rows_q <= best_rows_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.emit;
    end
  end

  assign done_o = done_q;
  assign tile_side_o = res_side_q;
  assign grid_columns_o = res_cols_q;
  assign grid_rows_o = res_rows_q;

endmodule

[rtl/core/square_tile_size_search.sv]
// Top level of the square tile size search: sequencer, datapath and shared divider.
// An item tries at most its tile count of column counts; a count of zero is taken as one and a
// count above MaxTiles as MaxTiles, so latency grows with the number of tries.
// The single one-bit-per-cycle divider (QW is the quotient width) serves up to three divisions per try.
// One item is worked on at a time; busy_o is high from acceptance until the result beat.
// Reset clears the control state only; the result beat is one cycle and cannot be stalled.
module square_tile_size_search #(
  parameter int DIM_BITS = sts_pkg::DimBitsDefault,
  parameter int FRAC_BITS = sts_pkg::FracBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [DIM_BITS-1:0]        rect_width_i,
  input  logic [DIM_BITS-1:0]        rect_height_i,
  input  logic [sts_pkg::CountW-1:0] tile_count_i,
  output logic                       done_o,
  output logic [sts_pkg::SideW-1:0]  tile_side_o,
  output logic [sts_pkg::CountW-1:0] grid_columns_o,
  output logic [sts_pkg::CountW-1:0] grid_rows_o
);

  localparam int QW = (DIM_BITS + FRAC_BITS > sts_pkg::CountW) ?
                      DIM_BITS + FRAC_BITS : sts_pkg::CountW;

  sts_pkg::ctrl_t             ctrl;
  sts_pkg::stat_t             stat;
  logic [QW-1:0]              dividend;
  logic [sts_pkg::CountW-1:0] divisor;
  logic [QW-1:0]              quotient;
  logic [sts_pkg::CountW-1:0] remainder;
  logic                       div_done;

  sts_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .div_done_i (div_done),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .busy_o     (busy_o)
  );

  sts_divider #(
    .QW (QW),
    .DW (sts_pkg::CountW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ctrl.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .done_o      (div_done)
  );

  sts_datapath #(
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .tile_count_i   (tile_count_i),
    .quotient_i     (quotient),
    .remainder_i    (remainder),
    .dividend_o     (dividend),
    .divisor_o      (divisor),
    .stat_o         (stat),
    .done_o         (done_o),
    .tile_side_o    (tile_side_o),
    .grid_columns_o (grid_columns_o),
    .grid_rows_o    (grid_rows_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("search ended without a result beat");

  a_counts_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> grid_columns_o != '0 && grid_rows_o != '0)
    else $error("zero column or row count in result");

endmodule

[tb/sv/tb_square_tile_size_search.sv]
// Self-checking testbench for the square tile size search: directed and random items.
module tb_square_tile_size_search;

  localparam int DimW = sts_pkg::DimBitsDefault;
  localparam int FracW = sts_pkg::FracBitsDefault;
  localparam int SideW = sts_pkg::SideW;
  localparam int CountW = sts_pkg::CountW;
  localparam int MaxTiles = sts_pkg::MaxTiles;
  localparam int TryCycles = 3 * (DimW + FracW + 2) + 3;
  localparam int TimeoutCycles = 4_000_000;

  typedef struct packed {
    logic [SideW-1:0]  side;
    logic [CountW-1:0] cols;
    logic [CountW-1:0] rows;
  } tile_fit_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [DimW-1:0]   rect_width_i = '0;
  logic [DimW-1:0]   rect_height_i = '0;
  logic [CountW-1:0] tile_count_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [SideW-1:0]  tile_side_o;
  logic [CountW-1:0] grid_columns_o;
  logic [CountW-1:0] grid_rows_o;

  tile_fit_t pending_fits[$];
  int        fail_count = 0;
  int        items_sent = 0;
  int        fits_checked = 0;
  bit        sender_idles = 1'b1;

  square_tile_size_search dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .rect_width_i,
    .rect_height_i,
    .tile_count_i,
    .done_o,
    .tile_side_o,
    .grid_columns_o,
    .grid_rows_o
  );

  always #6 clk_i = ~clk_i;

  function automatic tile_fit_t best_tile_fit(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                                              input logic [CountW-1:0] count);
    longint unsigned n, cols, rows, best, best_cols, best_rows, sx, sy, side;
    bit              searching;
    tile_fit_t       fit;
    n = count;
    if (n == 0) n = 1;
    if (n > MaxTiles) n = MaxTiles;
    cols = n;
    rows = 1;
    best = 0;
    best_cols = n;
    best_rows = 1;
    searching = 1'b1;
    while (searching) begin
      sx = (longint'(w) << FracW) / cols;
      sy = (longint'(h) << FracW) / rows;
      side = (sx < sy) ? sx : sy;
      if (side < best) begin
        searching = 1'b0;
      end else begin
        best = side;
        best_cols = cols;
        best_rows = rows;
        if (cols == 1) begin
          searching = 1'b0;
        end else begin
          cols = cols - 1;
          rows = (n + cols - 1) / cols;
        end
      end
    end
    fit.side = (best > 64'hFFFF_FFFF) ? '1 : best[SideW-1:0];
    fit.cols = best_cols[CountW-1:0];
    fit.rows = best_rows[CountW-1:0];
    return fit;
  endfunction

  function automatic logic [DimW-1:0] random_dim();
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3: return DimW'($urandom_range(1, 64));
      default: return DimW'($urandom);
    endcase
  endfunction

  task automatic report_failure(input string what, input longint unsigned expv,
                                input longint unsigned actv);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, expv, actv);
    end
  endtask

  always @(posedge clk_i) begin
    tile_fit_t want;
    if (rst_ni && done_o) begin
      fits_checked++;
      if (pending_fits.size() == 0) begin
        report_failure("unexpected result beat, side", 0, tile_side_o);
      end else begin
        want = pending_fits.pop_front();
        if (tile_side_o !== want.side) report_failure("tile_side", want.side, tile_side_o);
        if (grid_columns_o !== want.cols) report_failure("grid_columns", want.cols, grid_columns_o);
        if (grid_rows_o !== want.rows) report_failure("grid_rows", want.rows, grid_rows_o);
      end
    end
  end

  task automatic send_item(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                           input logic [CountW-1:0] count);
    int gap;
    start_i <= 1'b1;
    rect_width_i <= w;
    rect_height_i <= h;
    tile_count_i <= count;
    do @(posedge clk_i); while (busy_o);
    pending_fits.push_back(best_tile_fit(w, h, count));
    items_sent++;
    if (sender_idles && $urandom_range(99) < 28) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 250) : $urandom_range(1, 4);
      start_i <= 1'b0;
      // The idle stretch starts once the block is free again.
      do @(posedge clk_i); while (busy_o);
      repeat (gap - 1) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_extreme_fields();
    send_item(16'hFFFF, 16'hFFFF, 11'd1);
    send_item(16'd1, 16'd1, 11'd1);
    send_item(16'hFFFF, 16'd1, 11'd1023);
    send_item(16'd1, 16'hFFFF, 11'd37);
    send_item(16'hFFFF, 16'd3, 11'd2047);
    send_item(16'd12345, 16'd7, 11'd9);
    send_item(16'd7, 16'd12345, 11'd9);
    send_item(16'h8000, 16'h8000, 11'd16);
  endtask

  task automatic run_special_cases();
    send_item(16'd0, 16'd0, 11'd0);
    send_item(16'hFFFF, 16'hFFFF, 11'd0);
    send_item(16'd0, 16'd500, 11'd7);
    send_item(16'd500, 16'd0, 11'd5);
    send_item(16'd0, 16'd0, 11'd1024);
    send_item(16'd40000, 16'd2, 11'd1025);
    send_item(16'd10, 16'd10, 11'd5);
    send_item(16'd6, 16'd6, 11'd4);
    send_item(16'd3, 16'd7, 11'd3);
    // Hold the sender off until the block has answered everything so far.
    wait_for_results();
    repeat ($urandom_range(1, 30)) @(posedge clk_i);
  endtask

  task automatic run_random_items(input int count);
    logic [CountW-1:0] tiles;
    for (int i = 0; i < count; i++) begin
      sender_idles = !(i >= 40 && i < 80);
      tiles = ($urandom_range(19) == 0) ? '0 : CountW'($urandom_range(1, 32));
      send_item(random_dim(), random_dim(), tiles);
    end
    sender_idles = 1'b1;
  endtask

  task automatic run_full_range_counts(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_dim(), random_dim(), CountW'($urandom_range(0, 2047)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_extreme_fields();
    run_special_cases();
    run_random_items(126);
    run_full_range_counts(4);
    wait_for_results();
    repeat (2 * TryCycles) @(posedge clk_i);
    if (pending_fits.size() != 0) report_failure("results still outstanding", 0,
                                                 pending_fits.size());
    $display("Covered %0d items: field extremes, zero and saturated tile counts,", items_sent);
    $display("zero dimensions, ties and random rectangles; %0d result beats.", fits_checked);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(12 * TimeoutCycles);
    $display("Timeout with %0d results outstanding.", pending_fits.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[square_tile_size_search.f]
rtl/core/sts_pkg.sv
rtl/core/sts_divider.sv
rtl/core/sts_sequencer.sv
rtl/core/sts_datapath.sv
rtl/core/square_tile_size_search.sv
tb/sv/tb_square_tile_size_search.sv
